/* sv/assert_macros.svh */
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CHK_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that, once seen, requires a consequence in the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rwsd_pkg.sv */
// Types and constants shared by the rolling standard deviation block.
`default_nettype none

package rwsd_pkg;

   localparam int PRICE_W    = 24;
   localparam int STD_W      = 32;
   localparam int COUNT_W    = 6;
   localparam int FRAC_SHIFT = 16;
   localparam int QUOT_W     = 64;
   localparam int ROOT_W     = 32;
   localparam int SREM_W     = 34;
   localparam int CNT_W      = 7;
   localparam int MIN_COUNT  = 2;

   typedef enum logic {
      OP_ADD,
      OP_SUB
   } alu_op_type;

endpackage

`default_nettype wire

/* sv/rolling_window_std_deviation.sv */
// Top level of the rolling population standard deviation block.
//
// The request channel carries one 24-bit price per transaction; the response
// channel returns the standard deviation (8 fractional bits) and the number
// of prices held. Both channels use valid and stall: a transaction moves on a
// clock edge with valid high and stall low.
// Every step runs on one shared add/subtract unit under a sequencer. After a
// transaction is accepted the block stalls the request side until its result
// is in the output register. Once the window is full the square of the
// replaced price is taken out first. With fewer than two prices held the
// result is zero and the products, division and square root are skipped.
// Otherwise the result comes from the shift-add squares and products, the
// 64-step division and the 32-step square root. A waiting result does not
// hold up a new request; a finished computation waits while the receiver
// stalls. A synchronous reset empties the window and clears both running sums.
`default_nettype none

module rolling_window_std_deviation #(
   parameter int WINDOW = 50
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [rwsd_pkg::PRICE_W-1:0] req_price,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [rwsd_pkg::STD_W-1:0]   rsp_std_dev,
   output logic      [rwsd_pkg::COUNT_W-1:0] rsp_sample_count
);
   import rwsd_pkg::*;

   localparam int NW    = $clog2(WINDOW + 1);
   localparam int PTRW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SW    = PRICE_W + NW;
   localparam int QW    = 2 * PRICE_W + NW;
   localparam int DW    = QW + NW;
   localparam int NNW   = 2 * NW;
   localparam int UW    = DW;
   localparam int LOW_W = QUOT_W - FRAC_SHIFT;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SQ_OLD,
      ST_SQ_NEW,
      ST_SUM_SUB,
      ST_SUM_ADD,
      ST_NN,
      ST_NSQ,
      ST_SS,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } state_type;

   state_type              state_ff;
   logic [PRICE_W-1:0]     ring_mem [WINDOW];
   logic [PRICE_W-1:0]     old_ff;
   logic [PRICE_W-1:0]     price_ff;
   logic                   full_ff;
   logic [NW-1:0]          held_ff;
   logic [PTRW-1:0]        wpos_ff;
   logic [SW-1:0]          sum_ff;
   logic [QW-1:0]          sumsq_ff;
   logic [UW-1:0]          acc_ff;
   logic [UW-1:0]          acc_in;
   logic [UW-1:0]          mcand_ff;
   logic [SW-1:0]          mplier_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [NNW-1:0]         div_ff;
   logic [NNW-1:0]         rem_ff;
   logic [QUOT_W-1:0]      qr_ff;
   logic [SREM_W-1:0]      srem_ff;
   logic [ROOT_W-1:0]      root_ff;
   logic                   rsp_valid_ff;
   logic [STD_W-1:0]       rsp_std_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;
   logic [COUNT_W+NW-1:0]  count_ext;
   logic [UW-1:0]          unit_a;
   logic [UW-1:0]          unit_b;
   alu_op_type             unit_op;
   logic [UW-1:0]          unit_sum;
   logic                   unit_carry;
   logic                   accept;
   logic                   last_step;

   assign req_stall        = (state_ff != ST_IDLE);
   assign accept           = req_valid && !req_stall;
   assign last_step        = (cnt_ff == CNT_W'(1));
   assign count_ext        = {{COUNT_W{1'b0}}, held_ff};
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_std_dev      = rsp_std_ff;
   assign rsp_sample_count = rsp_count_ff;

   rwsd_addsub #(
      .WIDTH (UW)
   ) u_addsub (
      .a      (unit_a),
      .b      (unit_b),
      .op     (unit_op),
      .result (unit_sum),
      .carry  (unit_carry)
   );

   always_comb begin
      unit_a  = acc_ff;
      unit_b  = mcand_ff;
      unit_op = OP_ADD;
      unique case (state_ff)
         ST_SQ_OLD, ST_SS: begin
            unit_op = OP_SUB;
         end
         ST_SUM_SUB: begin
            unit_a  = UW'(sum_ff);
            unit_b  = full_ff ? UW'(old_ff) : '0;
            unit_op = OP_SUB;
         end
         ST_SUM_ADD: begin
            unit_a  = UW'(sum_ff);
            unit_b  = UW'(price_ff);
         end
         ST_DIV: begin
            unit_a  = UW'({rem_ff, qr_ff[QUOT_W-1]});
            unit_b  = UW'(div_ff);
            unit_op = OP_SUB;
         end
         ST_SQRT: begin
            unit_a  = UW'({srem_ff, qr_ff[QUOT_W-1 -: 2]});
            unit_b  = UW'({root_ff, 2'b01});
            unit_op = OP_SUB;
         end
         default: begin
         end
      endcase
      acc_in = mplier_ff[0] ? unit_sum : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ring_mem[wpos_ff] <= req_price;
         old_ff            <= ring_mem[wpos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         wpos_ff      <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  price_ff <= req_price;
                  full_ff  <= (held_ff == NW'(WINDOW));
                  if (held_ff != NW'(WINDOW)) begin
                     held_ff <= held_ff + 1'b1;
                  end
                  wpos_ff  <= (wpos_ff == PTRW'(WINDOW - 1)) ? '0 : wpos_ff + 1'b1;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               acc_ff <= UW'(sumsq_ff);
               cnt_ff <= CNT_W'(PRICE_W);
               if (full_ff) begin
                  mcand_ff  <= UW'(old_ff);
                  mplier_ff <= SW'(old_ff);
                  state_ff  <= ST_SQ_OLD;
               end else begin
                  mcand_ff  <= UW'(price_ff);
                  mplier_ff <= SW'(price_ff);
                  state_ff  <= ST_SQ_NEW;
               end
            end
            ST_SQ_OLD: begin
               acc_ff <= acc_in;
               if (last_step) begin
                  mcand_ff  <= UW'(price_ff);
                  mplier_ff <= SW'(price_ff);
                  cnt_ff    <= CNT_W'(PRICE_W);
                  state_ff  <= ST_SQ_NEW;
               end else begin
                  mcand_ff  <= mcand_ff << 1;
                  mplier_ff <= mplier_ff >> 1;
                  cnt_ff    <= cnt_ff - 1'b1;
               end
            end
            ST_SQ_NEW: begin
               acc_ff    <= acc_in;
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               cnt_ff    <= cnt_ff - 1'b1;
               if (last_step) begin
                  sumsq_ff <= acc_in[QW-1:0];
                  state_ff <= ST_SUM_SUB;
               end
            end
            ST_SUM_SUB: begin
               sum_ff   <= unit_sum[SW-1:0];
               state_ff <= ST_SUM_ADD;
            end
            ST_SUM_ADD: begin
               sum_ff <= unit_sum[SW-1:0];
               if (held_ff < NW'(MIN_COUNT)) begin
                  root_ff  <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  acc_ff    <= '0;
                  mcand_ff  <= UW'(held_ff);
                  mplier_ff <= SW'(held_ff);
                  cnt_ff    <= CNT_W'(NW);
                  state_ff  <= ST_NN;
               end
            end
            ST_NN: begin
               if (last_step) begin
                  div_ff    <= acc_in[NNW-1:0];
                  acc_ff    <= '0;
                  mcand_ff  <= UW'(sumsq_ff);
                  mplier_ff <= SW'(held_ff);
                  cnt_ff    <= CNT_W'(NW);
                  state_ff  <= ST_NSQ;
               end else begin
                  acc_ff    <= acc_in;
                  mcand_ff  <= mcand_ff << 1;
                  mplier_ff <= mplier_ff >> 1;
                  cnt_ff    <= cnt_ff - 1'b1;
               end
            end
            ST_NSQ: begin
               acc_ff <= acc_in;
               if (last_step) begin
                  mcand_ff  <= UW'(sum_ff);
                  mplier_ff <= sum_ff;
                  cnt_ff    <= CNT_W'(SW);
                  state_ff  <= ST_SS;
               end else begin
                  mcand_ff  <= mcand_ff << 1;
                  mplier_ff <= mplier_ff >> 1;
                  cnt_ff    <= cnt_ff - 1'b1;
               end
            end
            ST_SS: begin
               acc_ff    <= acc_in;
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               if (last_step) begin
                  rem_ff   <= acc_in[DW-1:LOW_W];
                  qr_ff    <= {acc_in[LOW_W-1:0], {FRAC_SHIFT{1'b0}}};
                  cnt_ff   <= CNT_W'(QUOT_W);
                  state_ff <= ST_DIV;
               end else begin
                  cnt_ff   <= cnt_ff - 1'b1;
               end
            end
            ST_DIV: begin
               qr_ff  <= {qr_ff[QUOT_W-2:0], unit_carry};
               rem_ff <= unit_carry ? unit_sum[NNW-1:0]
                                    : {rem_ff[NNW-2:0], qr_ff[QUOT_W-1]};
               if (last_step) begin
                  srem_ff  <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= CNT_W'(ROOT_W);
                  state_ff <= ST_SQRT;
               end else begin
                  cnt_ff   <= cnt_ff - 1'b1;
               end
            end
            ST_SQRT: begin
               qr_ff   <= qr_ff << 2;
               srem_ff <= unit_carry ? unit_sum[SREM_W-1:0]
                                     : {srem_ff[SREM_W-3:0], qr_ff[QUOT_W-1 -: 2]};
               root_ff <= {root_ff[ROOT_W-2:0], unit_carry};
               cnt_ff  <= cnt_ff - 1'b1;
               if (last_step) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_std_ff   <= root_ff;
                  rsp_count_ff <= count_ext[COUNT_W-1:0];
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* sv/rwsd_addsub.sv */
// Shared add/subtract unit with carry out used by every arithmetic step.
`default_nettype none

module rwsd_addsub #(
   parameter int WIDTH = 52
) (
   input  wire logic [WIDTH-1:0]      a,
   input  wire logic [WIDTH-1:0]      b,
   input  wire rwsd_pkg::alu_op_type  op,
   output logic      [WIDTH-1:0]      result,
   output logic                       carry
);
   import rwsd_pkg::*;

   logic [WIDTH:0] full_sum;

   // For a subtraction the carry is set when a is not below b.
   always_comb begin
      unique case (op)
         OP_SUB:  full_sum = {1'b0, a} + {1'b0, ~b} + (WIDTH+1)'(1);
         OP_ADD:  full_sum = {1'b0, a} + {1'b0, b};
         default: full_sum = {1'b0, a} + {1'b0, b};
      endcase
   end

   assign result = full_sum[WIDTH-1:0];
   assign carry  = full_sum[WIDTH];

endmodule

`default_nettype wire

/* sv/rwsd_checker.sv */
// Port-level checker for the rolling standard deviation block and its bind.
`default_nettype none
`include "assert_macros.svh"

module rwsd_checker #(
   parameter int WINDOW = 50
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic [rwsd_pkg::PRICE_W-1:0] req_price,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [rwsd_pkg::STD_W-1:0]   rsp_std_dev,
   input wire logic [rwsd_pkg::COUNT_W-1:0] rsp_sample_count
);
   import rwsd_pkg::*;

   localparam bit COUNT_FITS = (WINDOW < (1 << COUNT_W));

   logic req_accept;
   logic price_seen;

   assign req_accept = req_valid && !req_stall;
   assign price_seen = (req_price == req_price);

   // An accepted transaction must be followed by a stalled request side.
   `CHK_NEXT(a_busy_after_accept, clock, reset, req_accept && price_seen, req_stall, "request side not stalled after a transaction")

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_std_dev) && $stable(rsp_sample_count), "stalled response changed")

   // With fewer than two prices held the deviation must be zero.
   `CHK_HOLDS(a_small_window_zero, clock, reset, !(COUNT_FITS && rsp_valid && (rsp_sample_count < COUNT_W'(MIN_COUNT))) || (rsp_std_dev == '0), "nonzero deviation with fewer than two prices")

   `CHK_HOLDS(a_count_range, clock, reset, !(COUNT_FITS && rsp_valid) || ((rsp_sample_count != '0) && (rsp_sample_count <= COUNT_W'(WINDOW))), "sample count out of range")

endmodule

bind rolling_window_std_deviation rwsd_checker #(
   .WINDOW (WINDOW)
) u_rwsd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_price        (req_price),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_std_dev      (rsp_std_dev),
   .rsp_sample_count (rsp_sample_count)
);

`default_nettype wire
